// File: design/spdq_pkg.sv
package spdq_pkg;

    // fixed field widths
    localparam int PIN_W   = 6;
    localparam int CODE_W  = 3;
    localparam int CNT_W   = 3;
    localparam int DIV_W   = 8;
    localparam int STEP_W  = 8;
    localparam int HOLD_W  = 16;
    localparam int ADDR_W  = 3;
    localparam int CFG_W   = 16;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    // switch count supported by the board wiring
    localparam int NUM_SWITCHES = 6;
    localparam int SW_LIMIT_INT = (NUM_SWITCHES < PIN_W) ? NUM_SWITCHES : PIN_W;
    localparam logic [CNT_W-1:0] SW_LIMIT = CNT_W'(SW_LIMIT_INT);

    // register reset values
    localparam logic [CNT_W-1:0]  SWITCH_COUNT_RST   = CNT_W'(6);
    localparam logic [DIV_W-1:0]  SAMPLE_DIVIDER_RST = DIV_W'(10);
    localparam logic [STEP_W-1:0] HOLD_STEP_RST      = STEP_W'(10);
    localparam logic [HOLD_W-1:0] MIN_HOLD_RST       = HOLD_W'(200);
    localparam logic [HOLD_W-1:0] MAX_HOLD_RST       = HOLD_W'(2000);

    // register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_SWITCH_COUNT   = 3'd0,
        REG_SAMPLE_DIVIDER = 3'd1,
        REG_HOLD_STEP      = 3'd2,
        REG_MIN_HOLD       = 3'd3,
        REG_MAX_HOLD       = 3'd4
    } reg_idx_t;

    // item kinds
    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    typedef struct packed {
        logic [CNT_W-1:0]  switch_count;
        logic [DIV_W-1:0]  sample_divider;
        logic [STEP_W-1:0] hold_step;
        logic [HOLD_W-1:0] min_hold;
        logic [HOLD_W-1:0] max_hold;
    } cfg_t;

    typedef struct packed {
        action_t          action;
        logic [PIN_W-1:0] pin_levels;
    } item_t;

    typedef struct packed {
        logic [PIN_W-1:0]  pressed_switches;
        logic [CODE_W-1:0] press_code;
    } result_t;

endpackage

// File: design/spdq_cfg_regs.sv
module spdq_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [spdq_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [spdq_pkg::CFG_W-1:0]    cfg_wr_data,
    output spdq_pkg::cfg_t                cfg
);

    spdq_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.switch_count   <= spdq_pkg::SWITCH_COUNT_RST;
            cfg_reg.sample_divider <= spdq_pkg::SAMPLE_DIVIDER_RST;
            cfg_reg.hold_step      <= spdq_pkg::HOLD_STEP_RST;
            cfg_reg.min_hold       <= spdq_pkg::MIN_HOLD_RST;
            cfg_reg.max_hold       <= spdq_pkg::MAX_HOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                spdq_pkg::REG_SWITCH_COUNT:
                    cfg_reg.switch_count <= cfg_wr_data[spdq_pkg::CNT_W-1:0];
                spdq_pkg::REG_SAMPLE_DIVIDER:
                    cfg_reg.sample_divider <= cfg_wr_data[spdq_pkg::DIV_W-1:0];
                spdq_pkg::REG_HOLD_STEP:
                    cfg_reg.hold_step <= cfg_wr_data[spdq_pkg::STEP_W-1:0];
                spdq_pkg::REG_MIN_HOLD:
                    cfg_reg.min_hold <= cfg_wr_data[spdq_pkg::HOLD_W-1:0];
                spdq_pkg::REG_MAX_HOLD:
                    cfg_reg.max_hold <= cfg_wr_data[spdq_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/spdq_engine.sv
module spdq_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  spdq_pkg::item_t      item,
    input  spdq_pkg::cfg_t       cfg,
    output spdq_pkg::result_t    result
);

    logic [spdq_pkg::DIV_W-1:0]  prescale_reg, prescale_next;
    logic [spdq_pkg::PIN_W-1:0]  last_pattern_reg, last_pattern_next;
    logic [spdq_pkg::HOLD_W-1:0] hold_reg, hold_next;
    logic [spdq_pkg::CODE_W-1:0] code_reg, code_next;

    logic [spdq_pkg::CNT_W-1:0]  sw_n;
    logic [spdq_pkg::PIN_W-1:0]  mask;
    logic [spdq_pkg::PIN_W-1:0]  pattern;
    logic [spdq_pkg::CODE_W-1:0] single_code;
    logic [spdq_pkg::HOLD_W:0]   hold_sum;
    logic [spdq_pkg::DIV_W:0]    prescale_inc;
    logic [spdq_pkg::DIV_W-1:0]  div;
    logic                        in_window;

    always_comb begin
        sw_n = (cfg.switch_count > spdq_pkg::SW_LIMIT) ? spdq_pkg::SW_LIMIT
                                                        : cfg.switch_count;
        for (int i = 0; i < spdq_pkg::PIN_W; i++) begin
            mask[i] = (spdq_pkg::CNT_W'(i) < sw_n);
        end
        pattern = ~item.pin_levels & mask;

        // code of a lone held switch, zero otherwise
        single_code = '0;
        for (int i = 0; i < spdq_pkg::PIN_W; i++) begin
            if (last_pattern_reg == (spdq_pkg::PIN_W'(1) << i)) begin
                single_code = spdq_pkg::CODE_W'(i + 1);
            end
        end

        hold_sum  = {1'b0, hold_reg} + (spdq_pkg::HOLD_W + 1)'(cfg.hold_step);
        in_window = (hold_reg >= cfg.min_hold) && (hold_reg < cfg.max_hold);
        div       = (cfg.sample_divider == '0) ? spdq_pkg::DIV_W'(1)
                                               : cfg.sample_divider;
        prescale_inc = {1'b0, prescale_reg} + (spdq_pkg::DIV_W + 1)'(1);

        prescale_next     = prescale_reg;
        last_pattern_next = last_pattern_reg;
        hold_next         = hold_reg;
        code_next         = code_reg;

        if (step_en) begin
            if (item.action == spdq_pkg::ACT_CLEAR) begin
                code_next = '0;
            end else begin
                if (prescale_reg == '0) begin
                    if (pattern == '0 && pattern != last_pattern_reg) begin
                        if (code_reg == '0 && in_window && single_code != '0) begin
                            code_next = single_code;
                        end
                    end else if (pattern != '0 && pattern != last_pattern_reg) begin
                        hold_next = '0;
                    end else begin
                        hold_next = hold_sum[spdq_pkg::HOLD_W] ? '1
                                  : hold_sum[spdq_pkg::HOLD_W-1:0];
                    end
                    last_pattern_next = pattern;
                end
                prescale_next = (prescale_inc >= {1'b0, div}) ? '0
                              : prescale_inc[spdq_pkg::DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg     <= '0;
            last_pattern_reg <= '0;
            hold_reg         <= '0;
            code_reg         <= '0;
        end else begin
            prescale_reg     <= prescale_next;
            last_pattern_reg <= last_pattern_next;
            hold_reg         <= hold_next;
            code_reg         <= code_next;
        end
    end

    assign result.press_code       = code_next;
    assign result.pressed_switches = last_pattern_next;

endmodule

// File: design/switch_press_duration_qualifier.sv
// channel | direction | tdata (low bit up)                   | tuser
// s_      | in        | pin_levels[5:0], zero pad            | action
// m_      | out       | press_code[2:0], pressed_switches[8:3], zero pad | -
// cfg_    | in        | write enable, index, 16-bit data     | -
//
// one item per cycle sustained while m_tready holds high; each item goes through the input
// register and then the result register; first stage is the input register, the state
// update sits between it and the result register
// synchronous active-low reset clears both stages and the qualifier state
// a stall on m_ holds the result register; the input register still takes one
// more item before s_tready drops
module switch_press_duration_qualifier (
    input  logic                             aclk,
    input  logic                             aresetn,

    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [spdq_pkg::S_DATA_W-1:0]    s_tdata,   // pin_levels[5:0], zeros
    input  logic                             s_tuser,   // action

    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [spdq_pkg::M_DATA_W-1:0]    m_tdata,   // press_code[2:0], pressed_switches[8:3]

    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [spdq_pkg::ADDR_W-1:0]      cfg_addr,
    input  logic [spdq_pkg::CFG_W-1:0]       cfg_wr_data
);

    spdq_pkg::cfg_t    cfg;
    spdq_pkg::item_t   in_item_reg;
    spdq_pkg::result_t result;
    spdq_pkg::result_t out_data_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    logic              s_xfer;

    spdq_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // item moves from input register to result register when the latter frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    spdq_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg.action     <= spdq_pkg::action_t'(s_tuser);
            in_item_reg.pin_levels <= s_tdata[spdq_pkg::PIN_W-1:0];
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = spdq_pkg::M_DATA_W'(out_data_reg);

    // a clear transfer always shows an empty press code
    a_clear_zeroes_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.action == spdq_pkg::ACT_CLEAR)
            |=> (m_tdata[spdq_pkg::CODE_W-1:0] == '0))
        else $error("press code not zero after clear");

    // press code stays in its legal range
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[spdq_pkg::CODE_W-1:0] <= spdq_pkg::CODE_W'(spdq_pkg::NUM_SWITCHES)))
        else $error("press code out of range");

    // empty input stage always takes a transfer
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("result register overwritten while stalled");

endmodule

// File: sim/switch_press_duration_qualifier_tb.sv
module switch_press_duration_qualifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no transfer on either side before the run is abandoned
    localparam int IDLE_LIMIT    = 1000;
    // pipeline is two stages deep, give it a little more before touching registers
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    // unchanged samples at the largest step that carry the hold counter past its top
    localparam int SAT_TICKS     = 262;

    // one row of the directed table; known rows carry their own expected result
    typedef struct packed {
        spdq_pkg::action_t                act;
        logic [spdq_pkg::PIN_W-1:0]       pins;
        logic                             known;
        logic [spdq_pkg::CODE_W-1:0]      code;
        logic [spdq_pkg::PIN_W-1:0]       pressed;
    } directed_row_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE
    } ready_mode_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input stream
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [spdq_pkg::S_DATA_W-1:0] s_tdata  = '0;   // pin_levels[5:0], zeros
    logic                          s_tuser  = 1'b0; // action

    // result stream
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [spdq_pkg::M_DATA_W-1:0] m_tdata;  // press_code[2:0], pressed_switches[8:3], zeros

    // register write port
    logic                          cfg_wr_en   = 1'b0;
    logic [spdq_pkg::ADDR_W-1:0]   cfg_addr    = '0;
    logic [spdq_pkg::CFG_W-1:0]    cfg_wr_data = '0;

    // predictor copy of the registers, starting from their reset values
    logic [spdq_pkg::CNT_W-1:0]  cfg_sw_count = spdq_pkg::SWITCH_COUNT_RST;
    logic [spdq_pkg::DIV_W-1:0]  cfg_divider  = spdq_pkg::SAMPLE_DIVIDER_RST;
    logic [spdq_pkg::STEP_W-1:0] cfg_step     = spdq_pkg::HOLD_STEP_RST;
    logic [spdq_pkg::HOLD_W-1:0] cfg_min_hold = spdq_pkg::MIN_HOLD_RST;
    logic [spdq_pkg::HOLD_W-1:0] cfg_max_hold = spdq_pkg::MAX_HOLD_RST;

    // predictor copy of the qualifier state
    logic [spdq_pkg::DIV_W-1:0]  tick_phase   = '0;
    logic [spdq_pkg::PIN_W-1:0]  held_pattern = '0;
    logic [spdq_pkg::HOLD_W-1:0] hold_count   = '0;
    logic [spdq_pkg::CODE_W-1:0] press_latch  = '0;

    spdq_pkg::result_t expected_presses [$];
    int                error_count = 0;
    int                items_sent  = 0;
    int                burst_left  = 0;
    int                idle_cycles = 0;
    ready_mode_t       ready_mode  = READY_ALWAYS;
    int                ready_left  = 0;

    // directed walk, run with divider 1, step 100, window 200..499, all six switches
    directed_row_t directed_rows [24] = '{
        '{spdq_pkg::ACT_TICK,  6'h3F, 1'b1, 3'd0, 6'h00},  // nothing pressed, hold grows anyway
        '{spdq_pkg::ACT_TICK,  6'h3E, 1'b1, 3'd0, 6'h01},  // switch 0 goes down
        '{spdq_pkg::ACT_TICK,  6'h3E, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h3E, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h3F, 1'b1, 3'd1, 6'h00},  // release right at min hold latches
        '{spdq_pkg::ACT_TICK,  6'h3D, 1'b0, 3'd0, 6'h00},  // switch 1 press while a code is held
        '{spdq_pkg::ACT_TICK,  6'h3D, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h3D, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h3F, 1'b1, 3'd1, 6'h00},  // earlier code stays latched
        '{spdq_pkg::ACT_CLEAR, 6'h15, 1'b1, 3'd0, 6'h00},  // clear, pin levels ignored
        '{spdq_pkg::ACT_TICK,  6'h00, 1'b0, 3'd0, 6'h00},  // every switch pressed
        '{spdq_pkg::ACT_TICK,  6'h00, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h00, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h3F, 1'b1, 3'd0, 6'h00},  // several held, rejected
        '{spdq_pkg::ACT_TICK,  6'h1F, 1'b0, 3'd0, 6'h00},  // top switch
        '{spdq_pkg::ACT_TICK,  6'h1F, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h3F, 1'b1, 3'd0, 6'h00},  // too short
        '{spdq_pkg::ACT_TICK,  6'h1F, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h1F, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h1F, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h1F, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h1F, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h1F, 1'b0, 3'd0, 6'h00},
        '{spdq_pkg::ACT_TICK,  6'h3F, 1'b1, 3'd0, 6'h00}   // hold equal to max, rejected
    };

    switch_press_duration_qualifier dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // 8 ns period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // switches that take part in sampling, count clamped to the wired pins
    function automatic logic [spdq_pkg::PIN_W-1:0] live_mask();
        int n;
        n = cfg_sw_count;
        if (n > spdq_pkg::NUM_SWITCHES) n = spdq_pkg::NUM_SWITCHES;
        if (n > spdq_pkg::PIN_W) n = spdq_pkg::PIN_W;
        return spdq_pkg::PIN_W'((1 << n) - 1);
    endfunction

    // advances the predictor by one transfer and returns the result it should cause
    function automatic spdq_pkg::result_t qualify_item(input spdq_pkg::action_t act,
                                                      input logic [spdq_pkg::PIN_W-1:0] pins);
        int unsigned                div;
        int unsigned                sum;
        logic [spdq_pkg::PIN_W-1:0] pat;
        spdq_pkg::result_t          res;
        if (act == spdq_pkg::ACT_CLEAR) begin
            press_latch = '0;
        end else begin
            div = (cfg_divider == 0) ? 1 : cfg_divider;
            if (tick_phase == 0) begin
                pat = ~pins & live_mask();
                if (pat == 0 && pat != held_pattern) begin
                    // release: latch only a lone switch held inside the window
                    if (press_latch == 0 && hold_count >= cfg_min_hold
                            && hold_count < cfg_max_hold) begin
                        for (int i = 0; i < spdq_pkg::PIN_W; i++) begin
                            if (held_pattern == spdq_pkg::PIN_W'(1 << i))
                                press_latch = spdq_pkg::CODE_W'(i + 1);
                        end
                    end
                end else if (pat != 0 && pat != held_pattern) begin
                    hold_count = '0;
                end else begin
                    // hold counter saturates instead of wrapping
                    sum = hold_count + cfg_step;
                    hold_count = (sum > 32'hFFFF) ? 16'hFFFF : sum[spdq_pkg::HOLD_W-1:0];
                end
                held_pattern = pat;
            end
            // phase may sit above a freshly lowered divider, it wraps on the next tick
            if (tick_phase + 1 >= div)
                tick_phase = '0;
            else
                tick_phase = tick_phase + 1'b1;
        end
        res.press_code       = press_latch;
        res.pressed_switches = held_pattern;
        return res;
    endfunction

    // pin levels for a pressed pattern, masked pins get random levels
    function automatic logic [spdq_pkg::PIN_W-1:0] pins_for(
            input logic [spdq_pkg::PIN_W-1:0] pressed);
        logic [spdq_pkg::PIN_W-1:0] mask;
        mask = live_mask();
        return (~pressed & mask) | (spdq_pkg::PIN_W'($urandom) & ~mask);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // one transfer on the input stream, bursts separated by random gaps
    task automatic send_item(input spdq_pkg::action_t act,
                             input logic [spdq_pkg::PIN_W-1:0] pins,
                             input bit typed = 1'b0,
                             input spdq_pkg::result_t typed_res = '0);
        int                gap;
        spdq_pkg::result_t predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= spdq_pkg::S_DATA_W'(pins);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = qualify_item(act, pins);
        expected_presses.push_back(typed ? typed_res : predicted);
        burst_left--;
        items_sent++;
    endtask

    task automatic write_reg(input spdq_pkg::reg_idx_t idx,
                             input logic [spdq_pkg::CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            spdq_pkg::REG_SWITCH_COUNT:   cfg_sw_count = val[spdq_pkg::CNT_W-1:0];
            spdq_pkg::REG_SAMPLE_DIVIDER: cfg_divider  = val[spdq_pkg::DIV_W-1:0];
            spdq_pkg::REG_HOLD_STEP:      cfg_step     = val[spdq_pkg::STEP_W-1:0];
            spdq_pkg::REG_MIN_HOLD:       cfg_min_hold = val[spdq_pkg::HOLD_W-1:0];
            spdq_pkg::REG_MAX_HOLD:       cfg_max_hold = val[spdq_pkg::HOLD_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // registers change only once every result is home and the pipeline has emptied
    task automatic apply_config(input int sc, input int div, input int step,
                                input int min_h, input int max_h);
        while (expected_presses.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(spdq_pkg::REG_SWITCH_COUNT,   spdq_pkg::CFG_W'(sc));
        write_reg(spdq_pkg::REG_SAMPLE_DIVIDER, spdq_pkg::CFG_W'(div));
        write_reg(spdq_pkg::REG_HOLD_STEP,      spdq_pkg::CFG_W'(step));
        write_reg(spdq_pkg::REG_MIN_HOLD,       spdq_pkg::CFG_W'(min_h));
        write_reg(spdq_pkg::REG_MAX_HOLD,       spdq_pkg::CFG_W'(max_h));
        cfg_wr_en <= 1'b0;
    endtask

    // press, hold for a number of samples, release; with bounces and stray clears
    task automatic press_sequence(input int lmin, input int lmax);
        logic [spdq_pkg::PIN_W-1:0] pat;
        int                         div;
        int                         hold_ticks;
        int                         rel_ticks;
        div = (cfg_divider == 0) ? 1 : cfg_divider;
        if ($urandom_range(0, 3) != 0)
            pat = spdq_pkg::PIN_W'(1 << $urandom_range(0, spdq_pkg::PIN_W - 1));
        else
            pat = spdq_pkg::PIN_W'($urandom_range(1, 63));
        hold_ticks = $urandom_range(lmin, lmax) * div;
        for (int t = 0; t < hold_ticks; t++) begin
            if ($urandom_range(0, 59) == 0)
                send_item(spdq_pkg::ACT_CLEAR, spdq_pkg::PIN_W'($urandom));
            else if ($urandom_range(0, 79) == 0)
                send_item(spdq_pkg::ACT_TICK, spdq_pkg::PIN_W'($urandom));   // contact bounce
            else
                send_item(spdq_pkg::ACT_TICK, pins_for(pat));
        end
        rel_ticks = $urandom_range(1, 3) * div;
        for (int t = 0; t < rel_ticks; t++)
            send_item(spdq_pkg::ACT_TICK, pins_for('0));
    endtask

    // mostly well-formed presses, the rest noise ticks and clears
    task automatic run_phase(input int n, input int lmin, input int lmax);
        int start;
        start = items_sent;
        while (items_sent - start < n) begin
            case ($urandom_range(0, 9))
                0:       send_item(spdq_pkg::ACT_TICK, spdq_pkg::PIN_W'($urandom));
                1:       send_item(spdq_pkg::ACT_CLEAR, spdq_pkg::PIN_W'($urandom));
                default: press_sequence(lmin, lmax);
            endcase
        end
        s_tvalid <= 1'b0;
    endtask

    // result side stalls on its own pattern, switching now and then among always, random and sparse ready
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 2));
            ready_left <= $urandom_range(16, 96);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            default:      m_tready <= (ready_left % 4 == 0);
        endcase
    end

    // every result transfer is checked against the oldest expectation
    always @(posedge aclk) begin
        spdq_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_presses.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", m_tdata));
            end else begin
                want = expected_presses.pop_front();
                if (m_tdata[spdq_pkg::CODE_W-1:0] !== want.press_code)
                    report_mismatch($sformatf("press_code %0d, expected %0d",
                                              m_tdata[spdq_pkg::CODE_W-1:0],
                                              want.press_code));
                if (m_tdata[spdq_pkg::CODE_W+spdq_pkg::PIN_W-1:spdq_pkg::CODE_W]
                        !== want.pressed_switches)
                    report_mismatch($sformatf("pressed_switches %h, expected %h",
                        m_tdata[spdq_pkg::CODE_W+spdq_pkg::PIN_W-1:spdq_pkg::CODE_W],
                        want.pressed_switches));
            end
        end
    end

    // watchdog on transfers of either stream
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        spdq_pkg::result_t row_res;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        apply_config(6, 1, 100, 200, 500);
        foreach (directed_rows[i]) begin
            row_res.press_code       = directed_rows[i].code;
            row_res.pressed_switches = directed_rows[i].pressed;
            send_item(directed_rows[i].act, directed_rows[i].pins,
                      directed_rows[i].known, row_res);
        end
        s_tvalid <= 1'b0;

        // random phases over several register settings, extremes included
        apply_config(6, 1, 50, 100, 600);
        run_phase(40, 1, 16);
        // single switch, step of one, tiny window
        apply_config(1, 2, 1, 0, 8);
        run_phase(50, 1, 12);
        // count of zero masks every switch
        apply_config(0, 3, 20, 0, 65535);
        run_phase(20, 1, 8);
        // divider zero, count above the pins, one clean long hold drives the counter
        // into saturation
        apply_config(7, 0, 255, 1000, 65535);
        repeat (SAT_TICKS)
            send_item(spdq_pkg::ACT_TICK, pins_for(spdq_pkg::PIN_W'(1)));
        repeat (2)
            send_item(spdq_pkg::ACT_TICK, pins_for('0));
        run_phase(10, 1, 8);
        // coarse sampling, one sample per press
        apply_config(4, 24, 200, 0, 1000);
        run_phase(40, 1, 1);
        // zero step and empty window
        apply_config(6, 1, 0, 0, 0);
        run_phase(30, 1, 8);
        // window pinned at the top, nothing qualifies
        apply_config(5, 4, 30, 65535, 65535);
        run_phase(30, 1, 8);
        apply_config(2, 1, 255, 0, 65535);
        run_phase(40, 1, 10);
        // back to the power-up values
        apply_config(spdq_pkg::SWITCH_COUNT_RST, spdq_pkg::SAMPLE_DIVIDER_RST,
                     spdq_pkg::HOLD_STEP_RST, spdq_pkg::MIN_HOLD_RST,
                     spdq_pkg::MAX_HOLD_RST);
        run_phase(40, 1, 6);

        while (expected_presses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
design/spdq_pkg.sv
design/spdq_cfg_regs.sv
design/spdq_engine.sv
design/switch_press_duration_qualifier.sv
sim/switch_press_duration_qualifier_tb.sv
